// ===== hw/rtl/ilist_pkg.sv =====
// ilist_pkg: sizes, codes and shared types of the indexed insert/delete list
// no dependencies

package ilist_pkg;

   // store size and derived widths
   localparam int CAPACITY = 1024;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int KIND_W = 3;
   localparam int POS_W  = 12;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 11;

   // common width for position vs count compares
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // read select tree: first level picks within a group, second across groups
   localparam int LO_W     = (IDX_W > 1) ? IDX_W / 2 : 1;
   localparam int GRP_SIZE = 2 ** LO_W;
   localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
   localparam int HI_W     = (NUM_GRP > 2) ? $clog2(NUM_GRP) : 1;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INS_POS  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DEL_POS  = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [VAL_W-1:0] val_type;

   // broadcast to every cell
   typedef struct packed {
      logic    ins;
      logic    del;
      idx_type pos;
      val_type val;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/ilist_if.sv =====
// ilist_req_if / ilist_rsp_if: valid/ready channels of the list block
// depends on ilist_pkg

interface ilist_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [ilist_pkg::KIND_W-1:0]           kind;
   logic signed [ilist_pkg::POS_W-1:0]     position;
   logic signed [ilist_pkg::VAL_W-1:0]     value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ilist_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ilist_pkg::VAL_W-1:0]     read_value;
   logic [ilist_pkg::STAT_W-1:0]           status;
   logic [ilist_pkg::LEN_W-1:0]            length;

   modport source (output valid, read_value, status, length, input ready);
   modport sink   (input valid, read_value, status, length, output ready);
endinterface

// ===== hw/rtl/ilist_cell.sv =====
// ilist_cell: one slot of the list, shifts with its neighbors
// depends on ilist_pkg

module ilist_cell (
   input  logic                     clock,
   input  ilist_pkg::idx_type       cell_idx,
   input  ilist_pkg::cell_ctrl_type ctrl,
   input  ilist_pkg::val_type       lower_val,
   input  ilist_pkg::val_type       upper_val,
   output ilist_pkg::val_type       val_ff
);

   ilist_pkg::val_type val_in;

   always_comb begin
      val_in = val_ff;
      if (ctrl.ins) begin
         if (cell_idx > ctrl.pos) begin
            val_in = lower_val;
         end else if (cell_idx == ctrl.pos) begin
            val_in = ctrl.val;
         end
      end else if (ctrl.del && cell_idx >= ctrl.pos) begin
         val_in = upper_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== hw/rtl/ilist_rd_sel.sv =====
// ilist_rd_sel: registered first-level read select over one group of cells
// depends on ilist_pkg

module ilist_rd_sel (
   input  logic                                   clock,
   input  logic [ilist_pkg::LO_W-1:0]             sel,
   input  ilist_pkg::val_type                     grp_val [ilist_pkg::GRP_SIZE],
   output ilist_pkg::val_type                     dout_ff
);

   always_ff @(posedge clock) begin
      dout_ff <= grp_val[sel];
   end

endmodule

// ===== hw/rtl/indexed_insert_delete_list.sv =====
// indexed_insert_delete_list: ordered store of signed values kept in a chain of cells
// depends on ilist_pkg, ilist_if.sv, ilist_cell, ilist_rd_sel
//
//   channel  dir  handshake            payload
//   req_ch   in   valid/ready          kind, position, value
//   rsp_ch   out  valid/ready          read_value, status, length
//
// every request passes through capture, execute and result select
// inserts and deletes shift the cells from the position upward in the execute cycle
// reads go through a two-level registered select tree (group, then across groups)
// synchronous reset clears the count and control; cell contents are not cleared
// a new request is taken while a result still waits in the response register
// a stalled response holds the block in the select cycle

module indexed_insert_delete_list (
   input  logic        clock,
   input  logic        reset,
   ilist_req_if.sink   req_ch,
   ilist_rsp_if.source rsp_ch
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SEL  = 2'd2;

   logic [1:0] state_ff, state_in;

   // captured request
   logic [ilist_pkg::KIND_W-1:0]       kind_ff;
   logic signed [ilist_pkg::POS_W-1:0] pos_ff;
   ilist_pkg::val_type                 val_ff;

   ilist_pkg::cnt_type cnt_ff, cnt_in;

   // outcome of the execute cycle
   logic [ilist_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                         rd_ok_ff, rd_ok_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   ilist_pkg::val_type            rsp_val_ff, rsp_val_in;
   logic [ilist_pkg::STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic [ilist_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   ilist_pkg::cell_ctrl_type ctrl;
   ilist_pkg::val_type       cell_val [ilist_pkg::CAPACITY];
   ilist_pkg::val_type       grp_out  [ilist_pkg::NUM_GRP];

   logic                             req_take;
   logic                             rsp_load;
   logic                             pos_inside;
   logic [ilist_pkg::CMP_W-1:0]      pos_u;
   logic [ilist_pkg::CMP_W-1:0]      cnt_w;
   logic [ilist_pkg::CMP_W-1:0]      ins_pos;
   ilist_pkg::idx_type               rd_idx;
   logic [ilist_pkg::HI_W-1:0]       hi_idx;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == S_SEL) && (!rsp_valid_ff || rsp_ch.ready);

   // position compares; pos_u only meaningful when position is non-negative
   assign pos_u      = ilist_pkg::CMP_W'($unsigned(pos_ff));
   assign cnt_w      = ilist_pkg::CMP_W'(cnt_ff);
   assign pos_inside = !pos_ff[ilist_pkg::POS_W-1] && (pos_u < cnt_w);
   assign rd_idx     = ilist_pkg::IDX_W'($unsigned(pos_ff));
   assign hi_idx     = ilist_pkg::HI_W'(rd_idx >> ilist_pkg::LO_W);

   // execute-cycle decision
   always_comb begin
      ctrl     = '0;
      ctrl.val = val_ff;
      ins_pos  = '0;
      stat_in  = stat_ff;
      rd_ok_in = rd_ok_ff;
      cnt_in   = cnt_ff;
      case (kind_ff)
         ilist_pkg::KIND_INS_TAIL: ins_pos = cnt_w;
         ilist_pkg::KIND_INS_POS: begin
            if (!pos_ff[ilist_pkg::POS_W-1]) begin
               ins_pos = pos_u;
            end
         end
         default: ins_pos = '0;
      endcase
      ctrl.pos = ilist_pkg::IDX_W'(ins_pos);
      if (state_ff == S_EXEC) begin
         stat_in  = ilist_pkg::ST_DONE;
         rd_ok_in = 1'b0;
         case (kind_ff)
            ilist_pkg::KIND_READ: begin
               rd_ok_in = pos_inside;
               if (!pos_inside) begin
                  stat_in = ilist_pkg::ST_RANGE;
               end
            end
            ilist_pkg::KIND_INS_HEAD, ilist_pkg::KIND_INS_TAIL,
            ilist_pkg::KIND_INS_POS: begin
               if (ins_pos > cnt_w) begin
                  stat_in = ilist_pkg::ST_RANGE;
               end else if (cnt_w >= ilist_pkg::CMP_W'(ilist_pkg::CAPACITY)) begin
                  stat_in = ilist_pkg::ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
            ilist_pkg::KIND_DEL_POS: begin
               if (pos_inside) begin
                  ctrl.del = 1'b1;
                  ctrl.pos = rd_idx;
                  cnt_in   = cnt_ff - 1'b1;
               end else begin
                  stat_in = ilist_pkg::ST_RANGE;
               end
            end
            default: stat_in = ilist_pkg::ST_RANGE;
         endcase
      end
   end

   // chain of cells, each fed by both neighbors
   for (genvar i = 0; i < ilist_pkg::CAPACITY; i++) begin : g_cell
      ilist_pkg::val_type lo_v, up_v;
      if (i == 0) begin : g_first
         assign lo_v = '0;
      end else begin : g_lo
         assign lo_v = cell_val[i-1];
      end
      if (i == ilist_pkg::CAPACITY - 1) begin : g_last
         assign up_v = '0;
      end else begin : g_up
         assign up_v = cell_val[i+1];
      end
      ilist_cell u_cell (
         .clock     (clock),
         .cell_idx  (ilist_pkg::IDX_W'(i)),
         .ctrl      (ctrl),
         .lower_val (lo_v),
         .upper_val (up_v),
         .val_ff    (cell_val[i])
      );
   end

   // first read level: one registered select per group
   for (genvar g = 0; g < ilist_pkg::NUM_GRP; g++) begin : g_grp
      ilist_pkg::val_type gv [ilist_pkg::GRP_SIZE];
      for (genvar j = 0; j < ilist_pkg::GRP_SIZE; j++) begin : g_leaf
         if (g * ilist_pkg::GRP_SIZE + j < ilist_pkg::CAPACITY) begin : g_real
            assign gv[j] = cell_val[g * ilist_pkg::GRP_SIZE + j];
         end else begin : g_pad
            assign gv[j] = '0;
         end
      end
      ilist_rd_sel u_rd_sel (
         .clock   (clock),
         .sel     (rd_idx[ilist_pkg::LO_W-1:0]),
         .grp_val (gv),
         .dout_ff (grp_out[g])
      );
   end

   // state and response
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_len_in   = rsp_len_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_SEL;
         S_SEL: begin
            if (rsp_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               // second read level: pick across groups
               rsp_val_in   = rd_ok_ff ? grp_out[hi_idx] : '1;
               rsp_stat_in  = stat_ff;
               rsp_len_in   = ilist_pkg::LEN_W'(cnt_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_ch.kind;
         pos_ff  <= req_ch.position;
         val_ff  <= req_ch.value;
      end
      stat_ff     <= stat_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_val_ff;
   assign rsp_ch.status     = rsp_stat_ff;
   assign rsp_ch.length     = rsp_len_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ilist_pkg::CNT_W'(ilist_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_EXEC)
      else $error("accepted request did not start execution");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && ctrl.ins) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && ctrl.del) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("delete did not shrink the count");

   a_range_val: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff != ilist_pkg::ST_DONE) |-> rsp_val_ff == '1)
      else $error("failed request returned a value other than -1");
`endif

endmodule
